>>> hdl/stbs_pkg.sv
// shared types and constants for the sorted table search block
package stbs_pkg;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned POS_W = 10;

	// command codes on the mode port
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BOUND,
		ST_CMP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr;        // store value at entry_index
		logic load;      // latch target and open bounds
		logic probe;     // read the midpoint entry
		logic step;      // narrow bounds after a miss compare
		logic emit_hit;  // register a found result
		logic emit_miss; // register a not found result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_range; // lower bound below upper bound plus one
		logic hit;      // probed entry equals target
	} status_t;

endpackage

>>> hdl/stbs_ctrl.sv
// controller state machine for the sorted table search
module stbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              mode,
	input  stbs_pkg::status_t status,
	output stbs_pkg::cmd_t    cmd,
	output logic              busy
);

	stbs_pkg::state_t state_q;
	stbs_pkg::state_t state_next;
	logic             accept;

	assign accept = start && (state_q == stbs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (accept && (mode == stbs_pkg::MODE_SEARCH)) begin
					state_next = stbs_pkg::ST_BOUND;
				end
			end
			stbs_pkg::ST_BOUND: begin
				state_next = status.in_range ? stbs_pkg::ST_CMP : stbs_pkg::ST_IDLE;
			end
			stbs_pkg::ST_CMP: begin
				state_next = status.hit ? stbs_pkg::ST_IDLE : stbs_pkg::ST_BOUND;
			end
			default: begin
				state_next = stbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			stbs_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.wr    = accept && (mode == stbs_pkg::MODE_WRITE);
				cmd.load  = accept && (mode == stbs_pkg::MODE_SEARCH);
			end
			stbs_pkg::ST_BOUND: begin
				cmd.probe     = status.in_range;
				cmd.emit_miss = !status.in_range;
			end
			stbs_pkg::ST_CMP: begin
				cmd.emit_hit = status.hit;
				cmd.step     = !status.hit;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/stbs_dp.sv
// datapath for the sorted table search: table memory, bounds and result registers
module stbs_dp #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stbs_pkg::cmd_t                      cmd,
	output stbs_pkg::status_t                   status,
	input  logic [stbs_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [stbs_pkg::VAL_W-1:0]   value,
	input  logic                                cfg_we,
	input  logic [stbs_pkg::CNT_W-1:0]          cfg_wdata,
	output logic                                done,
	output logic                                found,
	output logic [stbs_pkg::POS_W-1:0]          position
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [stbs_pkg::VAL_W-1:0]        mem [TABLE_DEPTH];
	logic signed [stbs_pkg::VAL_W-1:0] rd_data_q;
	logic signed [stbs_pkg::VAL_W-1:0] target_q;
	logic [stbs_pkg::CNT_W-1:0]        element_count_q;
	logic [CW-1:0]                     lo_q;
	logic [CW-1:0]                     hi_p1_q;
	logic [AW-1:0]                     mid_q;
	logic [CW-1:0]                     mid;
	logic [CW-1:0]                     count_sat;
	logic                              wr_ok;
	logic                              done_q;
	logic                              found_q;
	logic [stbs_pkg::POS_W-1:0]        position_q;

	assign wr_ok = cmd.wr && (32'(entry_index) < 32'(TABLE_DEPTH));

	// count above depth is clamped to depth
	assign count_sat = (32'(element_count_q) > 32'(TABLE_DEPTH)) ?
		CW'(TABLE_DEPTH) : CW'(element_count_q);

	// hi_p1 is the inclusive upper bound plus one
	assign mid = lo_q + ((hi_p1_q - CW'(1) - lo_q) >> 1);

	assign status.in_range = lo_q < hi_p1_q;
	assign status.hit      = rd_data_q == target_q;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[AW'(entry_index)] <= value;
		end
		if (cmd.probe) begin
			rd_data_q <= mem[mid[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= value;
			lo_q     <= '0;
			hi_p1_q  <= count_sat;
		end else if (cmd.step) begin
			if (target_q < rd_data_q) begin
				hi_p1_q <= CW'(mid_q);
			end else begin
				lo_q <= CW'(mid_q) + CW'(1);
			end
		end
		if (cmd.probe) begin
			mid_q <= mid[AW-1:0];
		end
		if (cmd.emit_hit || cmd.emit_miss) begin
			found_q    <= cmd.emit_hit;
			position_q <= cmd.emit_hit ? stbs_pkg::POS_W'(mid_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
			done_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				element_count_q <= cfg_wdata;
			end
			done_q <= cmd.emit_hit || cmd.emit_miss;
		end
	end

	assign done     = done_q;
	assign found    = found_q;
	assign position = position_q;

endmodule

>>> hdl/sorted_table_binary_search.sv
// sorted table binary search: each probe is a bound check then a compare; a hit ends at a compare
// probes are at most ceil(log2(count+1)); a miss ends at a bound check; a write is a single store
// each probe is one registered table read plus a compare, using the single memory read port
// one transaction at a time: busy stays high until the result strobe, then start is taken again
// results are strobed on done for one cycle and cannot be stalled by the receiver
// arst_n clears the controller, element_count and done; table contents are undefined until written
module sorted_table_binary_search #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side: a transaction is taken when start is high and busy is low
	input  logic                              start,
	output logic                              busy,
	input  logic [0:0]                        mode,
	input  logic [stbs_pkg::IDX_W-1:0]        entry_index,
	input  logic signed [stbs_pkg::VAL_W-1:0] value,
	// element_count register, write only
	input  logic                              cfg_we,
	input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata,
	// result side: one transaction per search, marked by done
	output logic                              done,
	output logic [0:0]                        found,
	output logic [stbs_pkg::POS_W-1:0]        position
);

	stbs_pkg::cmd_t    cmd;
	stbs_pkg::status_t status;

	// controller: idle, bound check with read issue, compare with bound update
	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode[0]),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: table memory, search bounds, target and result registers
	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (entry_index),
		.value       (value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.found       (found[0]),
		.position    (position)
	);

endmodule
